FILE: sv/fpr_pkg.sv
`timescale 1ns / 1ps

package fpr_pkg;

  // frame geometry
  localparam int MAX_PAYLOAD    = 64;
  localparam int FRAME_OVERHEAD = 6;
  localparam int PREFIX_LEN     = 4;
  localparam int FRAME_MAX      = MAX_PAYLOAD + FRAME_OVERHEAD;

  // field widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 7;
  localparam int IDX_W  = 7;
  localparam int REQ_W  = 2;

  // two banks of frame bytes in one memory
  localparam int MEM_DEPTH = 2 * FRAME_MAX;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [POS_W-1:0] EXP_LEN_RST = POS_W'(10);

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register select, taken from paddr[2]
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_BYTE    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_READ    = 2'd2
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
  } hdr_cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic             read_hit;
    logic             frame_ready;
    logic [POS_W-1:0] frame_length;
    logic             frame_done;
    logic             frame_dropped;
    logic [POS_W-1:0] parse_position;
  } result_t;

  // bank 0 holds entries 0..FRAME_MAX-1, bank 1 the next FRAME_MAX
  function automatic logic [MEM_AW-1:0] mem_addr(logic bank, logic [POS_W-1:0] idx);
    logic [MEM_AW-1:0] base;
    base = MEM_AW'(idx);
    return bank ? base + MEM_AW'(FRAME_MAX) : base;
  endfunction

endpackage

FILE: sv/fpr_if.sv
`timescale 1ns / 1ps

interface fpr_in_if;
  logic                       valid;
  logic                       ready;
  logic [fpr_pkg::REQ_W-1:0]  req_type;
  logic [fpr_pkg::BYTE_W-1:0] rx_byte;
  logic [fpr_pkg::IDX_W-1:0]  read_index;

  modport source (output valid, output req_type, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input read_index,
                  output ready);
endinterface

interface fpr_out_if;
  logic                       valid;
  logic                       ready;
  logic [fpr_pkg::BYTE_W-1:0] read_data;
  logic                       frame_ready;
  logic [fpr_pkg::POS_W-1:0]  frame_length;
  logic                       frame_done;
  logic                       frame_dropped;
  logic [fpr_pkg::POS_W-1:0]  parse_position;

  modport source (output valid, output read_data, output frame_ready, output frame_length,
                  output frame_done, output frame_dropped, output parse_position,
                  input ready);
  modport sink   (input valid, input read_data, input frame_ready, input frame_length,
                  input frame_done, input frame_dropped, input parse_position,
                  output ready);
endinterface

FILE: sv/fpr_cfg_regs.sv
`timescale 1ns / 1ps

module fpr_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fpr_pkg::CFG_AW-1:0] paddr,
  input  logic [fpr_pkg::CFG_DW-1:0] pwdata,
  output logic [fpr_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output fpr_pkg::hdr_cfg_t          hdr_cfg
);

  localparam logic REG_SEL_FIRST  = fpr_pkg::REG_HEADER_FIRST;
  localparam logic REG_SEL_SECOND = fpr_pkg::REG_HEADER_SECOND;

  fpr_pkg::hdr_cfg_t hdr_r, hdr_nxt;
  logic              wr_fire;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;
  assign hdr_cfg = hdr_r;

  // word aligned bus: byte lane bits of paddr do not take part in the decode
  always_comb begin
    hdr_nxt = hdr_r;
    prdata  = '0;
    unique case (paddr[2])
      REG_SEL_FIRST: begin
        prdata[fpr_pkg::BYTE_W-1:0] = hdr_r.first;
        if (wr_fire) begin
          hdr_nxt.first = pwdata[fpr_pkg::BYTE_W-1:0];
        end
      end
      REG_SEL_SECOND: begin
        prdata[fpr_pkg::BYTE_W-1:0] = hdr_r.second;
        if (wr_fire) begin
          hdr_nxt.second = pwdata[fpr_pkg::BYTE_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
    end else begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

FILE: sv/fpr_parser.sv
`timescale 1ns / 1ps

module fpr_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [fpr_pkg::REQ_W-1:0]  req_type,
  input  logic [fpr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [fpr_pkg::IDX_W-1:0]  read_index,
  input  fpr_pkg::hdr_cfg_t          hdr_cfg,
  output fpr_pkg::mem_req_t          mem_req,
  output fpr_pkg::result_t           result
);

  localparam int FRAME_MAX = fpr_pkg::FRAME_MAX;
  localparam int POS_W     = fpr_pkg::POS_W;

  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     exp_r, exp_nxt;
  logic [POS_W-1:0]     hlen_r, hlen_nxt;
  // per entry: which bank holds the handed-off byte
  logic [FRAME_MAX-1:0] owner_r, owner_nxt;
  logic [FRAME_MAX-1:0] flip_mask;
  logic [POS_W-1:0]     pos_inc;
  logic                 prefix_ok;
  logic                 done;
  logic                 dropped;
  logic                 read_hit;

  assign pos_inc = pos_r + 1'b1;

  // entries below the completed length change hands on handoff
  always_comb begin
    for (int i = 0; i < FRAME_MAX; i++) begin
      flip_mask[i] = (POS_W'(i) < pos_inc);
    end
  end

  always_comb begin
    prefix_ok = ((pos_r == POS_W'(0)) && (rx_byte == hdr_cfg.first))  ||
                ((pos_r == POS_W'(1)) && (rx_byte == hdr_cfg.second)) ||
                (pos_r == POS_W'(2)) ||
                ((pos_r == POS_W'(3)) && (rx_byte <= fpr_pkg::BYTE_W'(fpr_pkg::MAX_PAYLOAD)));
  end

  always_comb begin
    pos_nxt   = pos_r;
    exp_nxt   = exp_r;
    hlen_nxt  = hlen_r;
    owner_nxt = owner_r;
    done      = 1'b0;
    dropped   = 1'b0;
    read_hit  = 1'b0;
    mem_req   = '0;
    // assembly always lands in the bank the handoff copy does not use
    mem_req.wr_addr = fpr_pkg::mem_addr(~owner_r[pos_r], pos_r);
    mem_req.wr_data = rx_byte;
    if (accept) begin
      case (fpr_pkg::req_t'(req_type))
        fpr_pkg::REQ_BYTE: begin
          if (pos_r < POS_W'(fpr_pkg::PREFIX_LEN)) begin
            if (prefix_ok) begin
              mem_req.wr_en = 1'b1;
              pos_nxt       = pos_inc;
              if (pos_r == POS_W'(3)) begin
                exp_nxt = POS_W'(rx_byte) + POS_W'(fpr_pkg::FRAME_OVERHEAD);
              end
            end else begin
              pos_nxt = '0;
            end
          end else if ((pos_r < exp_r) && (pos_r < POS_W'(FRAME_MAX))) begin
            mem_req.wr_en = 1'b1;
            pos_nxt       = pos_inc;
            if (pos_inc >= exp_r) begin
              pos_nxt = '0;
              if (hlen_r == '0) begin
                hlen_nxt  = pos_inc;
                owner_nxt = owner_r ^ flip_mask;
                done      = 1'b1;
              end else begin
                dropped = 1'b1;
              end
            end
          end
        end
        fpr_pkg::REQ_RELEASE: begin
          hlen_nxt = '0;
        end
        fpr_pkg::REQ_READ: begin
          if (read_index < fpr_pkg::IDX_W'(FRAME_MAX)) begin
            read_hit        = 1'b1;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = fpr_pkg::mem_addr(owner_r[read_index], read_index);
          end
        end
        default: begin
          read_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    result.read_hit       = read_hit;
    result.frame_ready    = (hlen_nxt != '0);
    result.frame_length   = hlen_nxt;
    result.frame_done     = done;
    result.frame_dropped  = dropped;
    result.parse_position = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      exp_r   <= fpr_pkg::EXP_LEN_RST;
      hlen_r  <= '0;
      owner_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      exp_r   <= exp_nxt;
      hlen_r  <= hlen_nxt;
      owner_r <= owner_nxt;
    end
  end

endmodule

FILE: sv/fpr_frame_mem.sv
`timescale 1ns / 1ps

module fpr_frame_mem (
  input  logic                       clk,
  input  fpr_pkg::mem_req_t          mem_req,
  output logic [fpr_pkg::BYTE_W-1:0] rd_data
);

  logic [fpr_pkg::BYTE_W-1:0] mem [fpr_pkg::MEM_DEPTH];
  logic [fpr_pkg::BYTE_W-1:0] rd_r;

  assign rd_data = rd_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_r <= mem[mem_req.rd_addr];
    end
  end

endmodule

FILE: sv/fpr_out_stage.sv
`timescale 1ns / 1ps

module fpr_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  fpr_pkg::result_t           result,
  input  logic [fpr_pkg::BYTE_W-1:0] rd_data,
  output logic                       in_ready,
  fpr_out_if.source                  out_chan
);

  // stage 1 waits for the memory read, stage 2 is the output register
  logic                       s1_valid_r, s1_valid_nxt;
  fpr_pkg::result_t           s1_res_r;
  logic                       out_valid_r, out_valid_nxt;
  fpr_pkg::result_t           out_res_r;
  logic [fpr_pkg::BYTE_W-1:0] out_data_r;
  logic                       s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= result;
    end
    if (s1_adv) begin
      out_res_r  <= s1_res_r;
      out_data_r <= s1_res_r.read_hit ? rd_data : '0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.read_data      = out_data_r;
  assign out_chan.frame_ready    = out_res_r.frame_ready;
  assign out_chan.frame_length   = out_res_r.frame_length;
  assign out_chan.frame_done     = out_res_r.frame_done;
  assign out_chan.frame_dropped  = out_res_r.frame_dropped;
  assign out_chan.parse_position = out_res_r.parse_position;

endmodule

FILE: sv/framed_packet_receiver_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake        word
// in_chan   in         valid / ready    req_type, rx_byte, read_index
// out_chan  out        valid / ready    read_data, frame_ready, frame_length,
//                                       frame_done, frame_dropped, parse_position
// apb       in / out   psel, penable    header_first at 0x0, header_second at 0x4
//
// one word per cycle sustained while out_chan.ready stays high; a result passes through the
// registered read of the frame memory in the read stage and then the output register
// synchronous active-low reset clears parser position, held length, bank owners, valids
// and header values, and loads the expected length with 10; frame memory is not cleared
// a stalled output holds one result in the output register and one in the read stage,
// after which in_chan.ready drops until out_chan.ready returns

module framed_packet_receiver_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  fpr_in_if.sink                     in_chan,
  fpr_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fpr_pkg::CFG_AW-1:0] paddr,
  input  logic [fpr_pkg::CFG_DW-1:0] pwdata,
  output logic [fpr_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  fpr_pkg::hdr_cfg_t          hdr_cfg;
  fpr_pkg::mem_req_t          mem_req;
  fpr_pkg::result_t           result;
  logic [fpr_pkg::BYTE_W-1:0] rd_data;
  logic                       in_ready;
  logic                       in_accept;

  assign in_chan.ready = in_ready;
  assign in_accept     = in_chan.valid && in_ready;

  // header match values
  fpr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hdr_cfg (hdr_cfg)
  );

  // position tracking and ping-pong bank ownership; a handoff only flips
  // the owner bits of the entries the new frame covers, so bytes past its
  // length still read back from the earlier handed-off frame
  fpr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .req_type   (in_chan.req_type),
    .rx_byte    (in_chan.rx_byte),
    .read_index (in_chan.read_index),
    .hdr_cfg    (hdr_cfg),
    .mem_req    (mem_req),
    .result     (result)
  );

  // both banks in one memory: assembly writes one bank while software
  // reads the other, so a write and a read never hit the same entry
  fpr_frame_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // read stage and output register
  fpr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .result   (result),
    .rd_data  (rd_data),
    .in_ready (in_ready),
    .out_chan (out_chan)
  );

endmodule
